// ===== hdl/sorted_list_store_assert.svh =====
// assertion macros for the sorted list store checker
// both sample on clk and stay quiet while rst_n is low
`ifndef SORTED_LIST_STORE_ASSERT_SVH
`define SORTED_LIST_STORE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define SLST_CHECK_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SLST_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/slst_pkg.sv =====
`timescale 1ns / 1ps

package slst_pkg;

    localparam int CAPACITY = 16;
    localparam int COUNT_W  = $clog2(CAPACITY + 1);
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 5;
    localparam int OP_W     = 3;
    localparam int STAT_W   = 2;

    // stream widths, padded to whole bytes
    localparam int IN_TDATA_W  = ((VALUE_W + POS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((VALUE_W + COUNT_W + 1 + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 3'd0,
        OP_POP    = 3'd1,
        OP_READ   = 3'd2,
        OP_KEEP   = 3'd3,
        OP_DROP   = 3'd4,
        OP_CLEAR  = 3'd5
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_DROP = 1'b1
    } state_t;

    // control broadcast to every cell
    typedef struct packed {
        logic                      ins;
        logic                      shl;
        logic signed [VALUE_W-1:0] value;
    } cell_ctrl_t;

endpackage

// ===== hdl/slst_cell.sv =====
`timescale 1ns / 1ps

module slst_cell (
    input  logic                               clk,
    input  slst_pkg::cell_ctrl_t               ctrl,
    input  logic                               valid,
    input  logic                               read_sel,
    input  logic                               prev_sel,
    input  logic signed [slst_pkg::VALUE_W-1:0] prev_entry,
    input  logic signed [slst_pkg::VALUE_W-1:0] next_entry,
    output logic                               sel,
    output logic signed [slst_pkg::VALUE_W-1:0] entry,
    output logic signed [slst_pkg::VALUE_W-1:0] rd_data
);
    import slst_pkg::*;

    logic signed [VALUE_W-1:0] entry_reg;
    logic signed [VALUE_W-1:0] entry_next;

    // empty cells and cells above the new value take part in the insert shift
    assign sel     = !valid || (entry_reg > ctrl.value);
    assign entry   = entry_reg;
    assign rd_data = read_sel ? entry_reg : '0;

    // first selected cell takes the new value, the rest take the left neighbor
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.ins && sel)
        begin
            entry_next = prev_sel ? prev_entry : ctrl.value;
        end
        else if (ctrl.shl)
        begin
            entry_next = next_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ===== hdl/sorted_list_store.sv =====
`timescale 1ns / 1ps

// Sorted store of 16 signed 32-bit values held in a row of cells, one value
// per cell, kept in ascending order; an insert lands after equal values. Insert,
// pop, read, keep-first, clear and a drop that empties the store or drops
// nothing are handled at once: the item is accepted, and its result sits in
// the output register on the next cycle. Drop-first of n entries, with n between
// one and the count less one, moves the row down by one cell per cycle and so
// holds the input until all n shifts are done; its result is loaded with the last
// shift. The input is also held while a finished result waits to be taken.
module sorted_list_store (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // value [31:0], position [36:32], zero fill above
    input  logic [slst_pkg::IN_TDATA_W-1:0]      s_tdata,
    // op [2:0]
    input  logic [slst_pkg::OP_W-1:0]            s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // data [31:0], entry_count [36:32], store_empty [37], zero fill above
    output logic [slst_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // status [1:0]
    output logic [slst_pkg::STAT_W-1:0]          m_tuser
);
    import slst_pkg::*;

    // input fields
    op_t                       op;
    logic signed [VALUE_W-1:0] in_value;
    logic [POS_W-1:0]          in_pos;
    logic                      in_fire;

    // control state
    state_t             state_reg, state_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [POS_W-1:0]   drop_left_reg, drop_left_next;
    logic               out_valid_reg, out_valid_next;

    // result register
    logic signed [VALUE_W-1:0] out_data_reg, out_data_next;
    logic [COUNT_W-1:0]        out_count_reg, out_count_next;
    status_t                   out_status_reg, out_status_next;
    logic                      out_load;

    // cell row wiring
    cell_ctrl_t                ctrl;
    logic [CAPACITY-1:0]       cell_valid;
    logic [CAPACITY-1:0]       cell_rsel;
    logic [CAPACITY-1:0]       cell_sel;
    logic signed [VALUE_W-1:0] cell_entry [CAPACITY];
    logic signed [VALUE_W-1:0] cell_rd    [CAPACITY];
    logic signed [VALUE_W-1:0] read_data;

    logic pos_in_range;
    logic drop_multi;

    assign op       = op_t'(s_tuser);
    assign in_value = s_tdata[VALUE_W-1:0];
    assign in_pos   = s_tdata[VALUE_W+POS_W-1:VALUE_W];
    assign s_tready = (state_reg == S_IDLE) && (!out_valid_reg || m_tready);
    assign in_fire  = s_tvalid && s_tready;

    assign pos_in_range = (in_pos != '0) && (POS_W'(in_pos) <= POS_W'(count_reg));
    assign drop_multi   = (in_pos != '0) && (POS_W'(in_pos) < POS_W'(count_reg));

    // row of cells, each linked to both neighbors
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        assign cell_valid[i] = COUNT_W'(i) < count_reg;
        assign cell_rsel[i]  = in_pos == POS_W'(i + 1);

        slst_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .valid      (cell_valid[i]),
            .read_sel   (cell_rsel[i]),
            .prev_sel   ((i == 0) ? 1'b0 : cell_sel[(i == 0) ? 0 : i - 1]),
            .prev_entry (cell_entry[(i == 0) ? 0 : i - 1]),
            .next_entry (cell_entry[(i == CAPACITY - 1) ? i : i + 1]),
            .sel        (cell_sel[i]),
            .entry      (cell_entry[i]),
            .rd_data    (cell_rd[i])
        );
    end

    // or together the masked cell outputs for a read
    always_comb
    begin
        read_data = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            read_data = read_data | cell_rd[i];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire && (op == OP_DROP) && drop_multi)
                begin
                    state_next = S_DROP;
                end
            end
            S_DROP:
            begin
                if (drop_left_reg == POS_W'(1))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // cell control, count and result
    always_comb
    begin
        ctrl            = '{ins: 1'b0, shl: 1'b0, value: in_value};
        count_next      = count_reg;
        drop_left_next  = drop_left_reg;
        out_load        = 1'b0;
        out_data_next   = '0;
        out_status_next = ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    out_load = 1'b1;
                    case (op)
                        OP_INSERT:
                        begin
                            if (count_reg == COUNT_W'(CAPACITY))
                            begin
                                out_status_next = ST_FULL;
                            end
                            else
                            begin
                                ctrl.ins   = 1'b1;
                                count_next = count_reg + COUNT_W'(1);
                            end
                        end
                        OP_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                out_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                ctrl.shl      = 1'b1;
                                out_data_next = cell_entry[0];
                                count_next    = count_reg - COUNT_W'(1);
                            end
                        end
                        OP_READ:
                        begin
                            if (pos_in_range)
                            begin
                                out_data_next = read_data;
                            end
                            else
                            begin
                                out_status_next = ST_RANGE;
                            end
                        end
                        OP_KEEP:
                        begin
                            if (POS_W'(in_pos) < POS_W'(count_reg))
                            begin
                                count_next = COUNT_W'(in_pos);
                            end
                        end
                        OP_DROP:
                        begin
                            if (drop_multi)
                            begin
                                // result comes at the end of the shift run
                                out_load       = 1'b0;
                                drop_left_next = in_pos;
                            end
                            else if (in_pos != '0)
                            begin
                                count_next = '0;
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            count_next = count_reg;
                        end
                    endcase
                end
            end
            S_DROP:
            begin
                // move the row down one cell per cycle
                ctrl.shl       = 1'b1;
                count_next     = count_reg - COUNT_W'(1);
                drop_left_next = drop_left_reg - POS_W'(1);
                out_load       = drop_left_reg == POS_W'(1);
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
        out_count_next = count_next;
    end

    // output register handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            drop_left_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            drop_left_reg <= drop_left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg   <= out_data_next;
            out_count_reg  <= out_count_next;
            out_status_reg <= out_status_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_TDATA_W - VALUE_W - COUNT_W - 1)'(0),
                       (out_count_reg == '0),
                       out_count_reg,
                       out_data_reg};
    assign m_tuser  = out_status_reg;

endmodule

// ===== hdl/slst_checker.sv =====
`timescale 1ns / 1ps
`include "sorted_list_store_assert.svh"

module slst_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 m_tvalid,
    input logic                                 m_tready,
    input logic [slst_pkg::OUT_TDATA_W-1:0]     m_tdata,
    input logic [slst_pkg::STAT_W-1:0]          m_tuser
);
    import slst_pkg::*;

    logic [COUNT_W-1:0] res_count;
    logic               res_empty;
    logic               res_full;
    logic [VALUE_W-1:0] res_data;

    assign res_data  = m_tdata[VALUE_W-1:0];
    assign res_count = m_tdata[VALUE_W+COUNT_W-1:VALUE_W];
    assign res_empty = m_tdata[VALUE_W+COUNT_W];
    assign res_full  = res_count == COUNT_W'(CAPACITY);

    // empty flag follows the reported count
    `SLST_CHECK_SAME(a_empty_flag, m_tvalid, res_empty == (res_count == '0), "empty flag mismatch")

    // count never passes the capacity
    `SLST_CHECK_SAME(a_count_max, m_tvalid, res_count <= COUNT_W'(CAPACITY), "count over capacity")

    // a refused insert only happens on a full store
    `SLST_CHECK_SAME(a_full_count, m_tvalid && (m_tuser == ST_FULL), res_full, "full on short store")

    // failed operations return zero data
    `SLST_CHECK_SAME(a_fail_data, m_tvalid && (m_tuser != ST_OK), res_data == '0, "data on failed item")

    // a stalled result stays valid
    `SLST_CHECK_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

endmodule

bind sorted_list_store slst_checker u_slst_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    import slst_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_UNUSED_7 = 3'd7;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int PHASES       = 14;
    localparam int PHASE_ITEMS  = 125;

    // one expected result item
    typedef struct packed {
        logic signed [VALUE_W-1:0] data;
        logic [COUNT_W-1:0]        count;
        logic                      empty;
        status_t                   status;
    } store_result_t;

    // one row of the directed stimulus
    typedef struct {
        logic [OP_W-1:0]           op;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          pos;
        bit                        typed;
        logic signed [VALUE_W-1:0] w_data;
        logic [COUNT_W-1:0]        w_count;
        status_t                   w_status;
    } stim_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic [OP_W-1:0]        s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [STAT_W-1:0]      m_tuser;

    // predicted store contents
    logic signed [VALUE_W-1:0] model_entries [CAPACITY];
    int                        model_count;

    store_result_t pending_results [$];
    stim_row_t     directed_rows [26];
    int            mismatch_count;
    int            cycle_count;
    bit            calm;

    sorted_list_store dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 12 ns clock
    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // apply one operation to the predicted store and return its result
    function automatic store_result_t predict_store_result(
        input logic [OP_W-1:0]           op,
        input logic signed [VALUE_W-1:0] val,
        input logic [POS_W-1:0]          pos
    );
        store_result_t r;
        int            idx;
        int            i;
        int            n;
        r.data   = '0;
        r.status = ST_OK;
        n        = int'(pos);
        case (op)
            OP_INSERT:
            begin
                if (model_count >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    // land after every equal value
                    idx = 0;
                    while (idx < model_count && model_entries[idx] <= val)
                        idx++;
                    for (i = model_count; i > idx; i--)
                        model_entries[i] = model_entries[i-1];
                    model_entries[idx] = val;
                    model_count++;
                end
            end
            OP_POP:
            begin
                if (model_count == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.data = model_entries[0];
                    for (i = 1; i < model_count; i++)
                        model_entries[i-1] = model_entries[i];
                    model_count--;
                end
            end
            OP_READ:
            begin
                if (n == 0 || n > model_count)
                    r.status = ST_RANGE;
                else
                    r.data = model_entries[n-1];
            end
            OP_KEEP:
            begin
                if (n < model_count)
                    model_count = n;
            end
            OP_DROP:
            begin
                if (n >= model_count)
                    model_count = 0;
                else if (n > 0)
                begin
                    for (i = n; i < model_count; i++)
                        model_entries[i-n] = model_entries[i];
                    model_count -= n;
                end
            end
            OP_CLEAR:
                model_count = 0;
            default:
                ;
        endcase
        r.count = model_count[COUNT_W-1:0];
        r.empty = (model_count == 0);
        return r;
    endfunction

    // idle length: mostly none, some short, a few long
    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm)
            return 0;
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // extremes, a narrow band for equal values, or anything
    function automatic logic signed [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
        begin
            case ($urandom_range(0, 4))
                0: return 32'sh80000000;
                1: return 32'sh7FFFFFFF;
                2: return 32'sh00000000;
                3: return 32'shFFFFFFFF;
                default: return 32'sh00000001;
            endcase
        end
        if (r < 50)
            return $signed($urandom_range(0, 8)) - 4;
        return $urandom;
    endfunction

    // positions mostly around the current count
    function automatic logic [POS_W-1:0] pick_pos();
        int hi;
        hi = (model_count + 1 > CAPACITY) ? CAPACITY : model_count + 1;
        if ($urandom_range(0, 99) < 70)
            return POS_W'($urandom_range(0, hi));
        return POS_W'($urandom_range(0, CAPACITY));
    endfunction

    function automatic logic [OP_W-1:0] pick_op(input int ins_w);
        int r;
        r = $urandom_range(0, 99);
        if (r < ins_w)
            return OP_INSERT;
        r = $urandom_range(0, 99);
        if (r < 2)
            return ($urandom_range(0, 1) != 0) ? OP_UNUSED_7 : OP_UNUSED_6;
        if (r < 32)
            return OP_POP;
        if (r < 62)
            return OP_READ;
        if (r < 74)
            return OP_KEEP;
        if (r < 94)
            return OP_DROP;
        return OP_CLEAR;
    endfunction

    // present one item, starting and ending at a falling edge
    task automatic send_item(
        input logic [OP_W-1:0]           op,
        input logic signed [VALUE_W-1:0] val,
        input logic [POS_W-1:0]          pos,
        input bit                        typed,
        input store_result_t             want
    );
        int            gap;
        store_result_t got;
        gap = rand_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(IN_TDATA_W-VALUE_W-POS_W){1'b0}}, pos, val};
        do
            @(posedge clk);
        while (!s_tready);
        got = predict_store_result(op, val, pos);
        pending_results.push_back(typed ? want : got);
        @(negedge clk);
    endtask

    task automatic send_random(input logic [OP_W-1:0] op);
        send_item(op, pick_value(), pick_pos(), 1'b0, '0);
    endtask

    // hold the input until every result has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (pending_results.size() != 0);
    endtask

    // compare each result item with the oldest expectation
    always @(posedge clk)
    begin
        store_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result item with no expectation: tdata %h tuser %0d", m_tdata, m_tuser);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[31:0] !== want.data)
                begin
                    $error("data: expected %0d, got %0d", want.data, $signed(m_tdata[31:0]));
                    mismatch_count++;
                end
                if (m_tdata[36:32] !== want.count)
                begin
                    $error("entry_count: expected %0d, got %0d", want.count, m_tdata[36:32]);
                    mismatch_count++;
                end
                if (m_tdata[37] !== want.empty)
                begin
                    $error("store_empty: expected %0d, got %0d", want.empty, m_tdata[37]);
                    mismatch_count++;
                end
                if (m_tuser !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser);
                    mismatch_count++;
                end
            end
        end
    end

    // run time guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver side stalls
    initial
    begin
        int g;
        m_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            g = rand_gap();
            if (g > 0)
            begin
                m_tready <= 1'b0;
                repeat (g) @(negedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
    end

    // stimulus
    initial
    begin
        store_result_t want;
        int            ins_w;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        mismatch_count = 0;
        cycle_count    = 0;
        calm           = 1'b0;
        model_count    = 0;
        for (int i = 0; i < CAPACITY; i++)
            model_entries[i] = '0;

        // op, value, position, typed, data, count, status
        directed_rows = '{
            '{OP_POP,      32'sh0,        5'd0,  1'b1, 32'sh0,        5'd0, ST_EMPTY},
            '{OP_READ,     32'sh0,        5'd1,  1'b1, 32'sh0,        5'd0, ST_RANGE},
            '{OP_DROP,     32'sh0,        5'd3,  1'b1, 32'sh0,        5'd0, ST_OK},
            '{OP_KEEP,     32'sh0,        5'd0,  1'b1, 32'sh0,        5'd0, ST_OK},
            '{OP_INSERT,   32'sh7FFFFFFF, 5'd0,  1'b1, 32'sh0,        5'd1, ST_OK},
            '{OP_INSERT,   32'sh80000000, 5'd31, 1'b1, 32'sh0,        5'd2, ST_OK},
            '{OP_INSERT,   32'sh0,        5'd0,  1'b1, 32'sh0,        5'd3, ST_OK},
            '{OP_INSERT,   32'sh0,        5'd0,  1'b1, 32'sh0,        5'd4, ST_OK},
            '{OP_INSERT,   32'shFFFFFFFF, 5'd0,  1'b1, 32'sh0,        5'd5, ST_OK},
            '{OP_READ,     32'sh0,        5'd0,  1'b1, 32'sh0,        5'd5, ST_RANGE},
            '{OP_READ,     32'shFFFFFFFF, 5'd1,  1'b1, 32'sh80000000, 5'd5, ST_OK},
            '{OP_READ,     32'sh0,        5'd5,  1'b1, 32'sh7FFFFFFF, 5'd5, ST_OK},
            '{OP_READ,     32'sh0,        5'd6,  1'b1, 32'sh0,        5'd5, ST_RANGE},
            '{OP_READ,     32'sh0,        5'd16, 1'b1, 32'sh0,        5'd5, ST_RANGE},
            '{OP_READ,     32'sh0,        5'd3,  1'b0, 32'sh0,        5'd0, ST_OK},
            '{OP_UNUSED_6, 32'sh5A5A5A5A, 5'd2,  1'b1, 32'sh0,        5'd5, ST_OK},
            '{OP_UNUSED_7, 32'shA5A5A5A5, 5'd1,  1'b1, 32'sh0,        5'd5, ST_OK},
            '{OP_POP,      32'sh0,        5'd0,  1'b0, 32'sh0,        5'd0, ST_OK},
            '{OP_KEEP,     32'sh0,        5'd16, 1'b0, 32'sh0,        5'd0, ST_OK},
            '{OP_KEEP,     32'sh0,        5'd3,  1'b0, 32'sh0,        5'd0, ST_OK},
            '{OP_DROP,     32'sh0,        5'd0,  1'b0, 32'sh0,        5'd0, ST_OK},
            '{OP_DROP,     32'sh0,        5'd2,  1'b0, 32'sh0,        5'd0, ST_OK},
            '{OP_INSERT,   32'sh12345678, 5'd0,  1'b0, 32'sh0,        5'd0, ST_OK},
            '{OP_DROP,     32'sh0,        5'd5,  1'b0, 32'sh0,        5'd0, ST_OK},
            '{OP_INSERT,   32'sh7,        5'd0,  1'b0, 32'sh0,        5'd0, ST_OK},
            '{OP_CLEAR,    32'sh0,        5'd0,  1'b1, 32'sh0,        5'd0, ST_OK}
        };

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed rows
        foreach (directed_rows[i])
        begin
            want.data   = directed_rows[i].w_data;
            want.count  = directed_rows[i].w_count;
            want.empty  = (directed_rows[i].w_count == 0);
            want.status = directed_rows[i].w_status;
            send_item(directed_rows[i].op, directed_rows[i].value, directed_rows[i].pos,
                      directed_rows[i].typed, want);
        end
        drain_results();

        // fill past capacity, then work on a full store
        repeat (CAPACITY + 1) send_item(OP_INSERT, pick_value(), 5'd0, 1'b0, '0);
        send_item(OP_READ, 32'sh0, 5'd16, 1'b0, '0);
        send_item(OP_KEEP, 32'sh0, 5'd16, 1'b0, '0);
        send_item(OP_DROP, 32'sh0, 5'd15, 1'b0, '0);
        send_item(OP_POP, 32'sh0, 5'd0, 1'b0, '0);

        // random phases with varying insert pressure
        for (int p = 0; p < PHASES; p++)
        begin
            if (p % 3 == 0)
                drain_results();
            calm = (p % 4 == 2);
            case ($urandom_range(0, 3))
                0: ins_w = 30;
                1: ins_w = 50;
                2: ins_w = 70;
                default: ins_w = 85;
            endcase
            repeat (PHASE_ITEMS) send_random(pick_op(ins_w));
        end
        calm = 1'b0;

        // wait out the remaining results
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
